// ===== sv/bpa_pkg.sv =====
// bpa_pkg: shared types and codes for the bitmap page allocator
// used by bpa_byte_unit and bitmap_page_allocator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // request codes as seen on req_type
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RESERVE = 2'd2;

  // operation applied to one bitmap byte
  typedef enum logic [1:0] {
    OP_SMALL = 2'd0,
    OP_LARGE = 2'd1,
    OP_REL   = 2'd2,
    OP_RES   = 2'd3
  } byte_op_e;

  // control from the sequencer to the byte unit
  typedef struct packed {
    byte_op_e   op;
    logic [2:0] count;  // run length of a small allocate
    logic [2:0] lo;     // first bit touched in this byte
    logic [3:0] hi;     // one past the last bit touched
  } byte_ctl_t;

  // status from the byte unit back to the sequencer
  typedef struct packed {
    logic [7:0] wdata;  // updated byte
    logic [3:0] delta;  // number of bits that changed
    logic       fit;    // small run fits in this byte
    logic [2:0] pos;    // lowest bit of that run
    logic       zero;   // byte fully free
  } byte_res_t;

endpackage

`default_nettype wire

// ===== sv/bpa_ram.sv =====
// bpa_ram: generic single write port, single read port RAM
// read data registered, valid in the cycle after the read enable; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bpa_byte_unit.sv =====
// bpa_byte_unit: shared byte datapath, masks, bit counts and run fit
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpa_byte_unit (
  input  wire logic              [7:0] data_i,
  input  wire bpa_pkg::byte_ctl_t      ctl_i,
  output bpa_pkg::byte_res_t           res_o
);

  import bpa_pkg::*;

  logic [7:0] range_mask;
  logic [7:0] run_mask;
  logic [7:0] changed;
  logic [7:0] wdata;
  logic [3:0] delta;
  logic       fit;
  logic [2:0] pos;

  // mask of bits lo..hi-1
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      range_mask[j] = (4'(j) >= {1'b0, ctl_i.lo}) && (4'(j) < ctl_i.hi);
    end
  end

  // lowest position where a small run of free bits fits
  always_comb begin
    logic [7:0] win;
    run_mask = 8'((16'd1 << ctl_i.count) - 16'd1);
    fit = 1'b0;
    pos = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      win = (data_i >> j) & run_mask;
      if ((win == 8'd0) && ((4'(j) + {1'b0, ctl_i.count}) <= 4'd8)) begin
        fit = 1'b1;
        pos = 3'(j);
      end
    end
  end

  // new byte value and the bits that flip
  always_comb begin
    wdata   = data_i;
    changed = 8'd0;
    case (ctl_i.op)
      OP_SMALL: begin
        wdata   = data_i | 8'(run_mask << pos);
        changed = 8'(run_mask << pos);
      end
      OP_REL: begin
        wdata   = data_i & ~range_mask;
        changed = data_i & range_mask;
      end
      OP_RES: begin
        wdata   = data_i | range_mask;
        changed = range_mask & ~data_i;
      end
      default: begin
        wdata   = data_i;
        changed = 8'd0;
      end
    endcase
  end

  // bit count of the flipped bits
  always_comb begin
    delta = 4'd0;
    for (int j = 0; j < 8; j++) begin
      delta = delta + {3'd0, changed[j]};
    end
  end

  // status back to the sequencer
  assign res_o = {wdata, delta, fit, pos, (data_i == 8'd0)};

endmodule

`default_nettype wire

// ===== sv/bitmap_page_allocator.sv =====
// Bitmap page allocator, one bitmap byte per cycle through the RAM read port.
// A walk over a range or map reads and evaluates its bytes in turn; an allocate stops once a
// small run fits in a byte or a large run has its free bytes, which ST_FILL then marks full.
// A zero count, unknown type or empty range goes straight to ST_DONE; an empty map is not read.
// Throughput: one word at a time; input ready only while the sequencer is idle.
// Reset (rst_ni low, async) and every pages_managed write clear every map byte in ST_CLEAR.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [12:0] page_count_i,
  input  wire logic [11:0] start_page_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic      [11:0] result_page_o,
  output logic      [12:0] used_pages_o
);

  import bpa_pkg::*;

  localparam int unsigned MapBytes   = MAX_PAGES / 8;
  localparam int unsigned AW         = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int unsigned BW         = $clog2(MapBytes + 1);
  localparam int unsigned PW         = (BW + 3 > 14) ? BW + 3 : 14;
  localparam int unsigned ResetBytes = (MapBytes < 512) ? MapBytes : 512;
  localparam logic        RegPages   = 1'b0;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FILL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [12:0] pm_q, pm_d;
  logic [BW-1:0] nbytes_q, nbytes_d;
  logic [12:0] used_q, used_d;
  logic [BW-1:0] clr_q, clr_d;
  byte_op_e    op_q, op_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [10:0] need_q, need_d;
  logic [BW-1:0] iss_q, iss_d;
  logic [BW-1:0] iss_end_q, iss_end_d;
  logic [BW-1:0] first_q, first_d;
  logic [BW-1:0] last_q, last_d;
  logic [BW-1:0] ev_q, ev_d;
  logic        pend_q, pend_d;
  logic [2:0]  lo_q, lo_d;
  logic [3:0]  hi_q, hi_d;
  logic [10:0] run_q, run_d;
  logic [BW-1:0] runst_q, runst_d;
  logic [BW-1:0] fill_q, fill_d;
  logic [10:0] fillcnt_q, fillcnt_d;
  logic        rok_q, rok_d;
  logic [11:0] rpage_q, rpage_d;
  logic        out_valid_q;
  logic        out_ok_q;
  logic [11:0] out_page_q;
  logic [12:0] out_used_q;

  logic        cfg_wr;
  logic        accept;
  logic        out_load;
  logic        issue;
  logic        ram_we;
  logic        ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;
  logic [31:0] wr_bytes;
  logic [BW-1:0] nb_new;
  logic [PW-1:0] lim_pg;
  logic [PW-1:0] rs_pg;
  logic [PW-1:0] end_raw;
  logic [PW-1:0] end_eff;
  logic [PW-1:0] end_m1;
  logic        range_empty;
  logic [BW-1:0] large_start;
  byte_ctl_t   uctl;
  byte_res_t   ures;

  // configuration port
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == RegPages);
  assign prdata   = (paddr[2] == RegPages) ? {19'd0, pm_q} : 32'd0;
  assign wr_bytes = 32'(pwdata[12:3]);
  assign nb_new   = (wr_bytes > MapBytes) ? BW'(MapBytes) : BW'(wr_bytes);

  // handshakes
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign result_page_o = out_page_q;
  assign used_pages_o  = out_used_q;

  // page range of a release or reserve, clipped to the managed pages
  always_comb begin
    lim_pg = PW'({nbytes_q, 3'b000});
    if (req_type_i == REQ_RELEASE) begin
      rs_pg   = PW'(start_page_i);
      end_raw = PW'(start_page_i) + PW'(page_count_i);
    end else begin
      rs_pg   = '0;
      end_raw = PW'(page_count_i);
    end
    end_eff     = (end_raw < lim_pg) ? end_raw : lim_pg;
    range_empty = (end_eff <= rs_pg);
    end_m1      = end_eff - PW'(1);
  end

  // byte unit control
  assign uctl.op    = op_q;
  assign uctl.count = cnt_q;
  assign uctl.lo    = (ev_q == first_q) ? lo_q : 3'd0;
  assign uctl.hi    = (ev_q == last_q) ? hi_q : 4'd8;

  bpa_byte_unit u_byte (
    .data_i (ram_rdata),
    .ctl_i  (uctl),
    .res_o  (ures)
  );

  assign issue       = (iss_q < iss_end_q);
  assign ram_re      = (state_q == ST_SCAN) && issue;
  assign large_start = (run_q == 11'd0) ? ev_q : runst_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    pm_d      = pm_q;
    nbytes_d  = nbytes_q;
    used_d    = used_q;
    clr_d     = clr_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    need_d    = need_q;
    iss_d     = iss_q;
    iss_end_d = iss_end_q;
    first_d   = first_q;
    last_d    = last_q;
    ev_d      = ev_q;
    pend_d    = pend_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    run_d     = run_q;
    runst_d   = runst_q;
    fill_d    = fill_q;
    fillcnt_d = fillcnt_q;
    rok_d     = rok_q;
    rpage_d   = rpage_q;
    ram_we    = 1'b0;
    ram_waddr = ev_q[AW-1:0];
    ram_wdata = ures.wdata;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        ram_wdata = 8'd0;
        clr_d     = clr_q + BW'(1);
        if (clr_q == BW'(MapBytes - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          run_d  = 11'd0;
          pend_d = 1'b0;
          case (req_type_i)
            REQ_ALLOC: begin
              rok_d     = 1'b0;
              rpage_d   = 12'd0;
              iss_d     = '0;
              iss_end_d = nbytes_q;
              cnt_d     = page_count_i[2:0];
              need_d    = 11'((14'(page_count_i) + 14'd7) >> 3);
              if (page_count_i == 13'd0) begin
                state_d = ST_DONE;
              end else if (page_count_i < 13'd8) begin
                op_d    = OP_SMALL;
                state_d = ST_SCAN;
              end else begin
                op_d    = OP_LARGE;
                state_d = ST_SCAN;
              end
            end
            REQ_RELEASE, REQ_RESERVE: begin
              rok_d     = 1'b1;
              rpage_d   = (req_type_i == REQ_RELEASE) ? start_page_i : 12'd0;
              op_d      = (req_type_i == REQ_RELEASE) ? OP_REL : OP_RES;
              first_d   = BW'(rs_pg >> 3);
              last_d    = BW'(end_m1 >> 3);
              iss_d     = BW'(rs_pg >> 3);
              iss_end_d = BW'(end_m1 >> 3) + BW'(1);
              lo_d      = rs_pg[2:0];
              hi_d      = {1'b0, end_m1[2:0]} + 4'd1;
              state_d   = range_empty ? ST_DONE : ST_SCAN;
            end
            default: begin
              rok_d   = 1'b0;
              rpage_d = 12'd0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue the next byte read, evaluate the byte read last cycle
        if (issue) begin
          iss_d = iss_q + BW'(1);
          ev_d  = iss_q;
        end
        pend_d = issue;
        if (pend_q) begin
          case (op_q)
            OP_SMALL: begin
              if (ures.fit) begin
                ram_we  = 1'b1;
                used_d  = used_q + 13'(ures.delta);
                rok_d   = 1'b1;
                rpage_d = 12'({ev_q, ures.pos});
                pend_d  = 1'b0;
                state_d = ST_DONE;
              end
            end
            OP_LARGE: begin
              if (ures.zero) begin
                runst_d = large_start;
                run_d   = run_q + 11'd1;
                if ((run_q + 11'd1) == need_q) begin
                  fill_d    = large_start;
                  fillcnt_d = need_q;
                  rok_d     = 1'b1;
                  rpage_d   = 12'({large_start, 3'b000});
                  pend_d    = 1'b0;
                  state_d   = ST_FILL;
                end
              end else begin
                run_d = 11'd0;
              end
            end
            OP_REL: begin
              ram_we = 1'b1;
              used_d = used_q - 13'(ures.delta);
            end
            OP_RES: begin
              ram_we = 1'b1;
              used_d = used_q + 13'(ures.delta);
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end else if (!issue) begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        // mark whole bytes of a large run
        ram_we    = 1'b1;
        ram_waddr = fill_q[AW-1:0];
        ram_wdata = 8'hFF;
        used_d    = used_q + 13'd8;
        fill_d    = fill_q + BW'(1);
        fillcnt_d = fillcnt_q - 11'd1;
        if (fillcnt_q == 11'd1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a pages_managed write restarts with an empty bitmap
    if (cfg_wr) begin
      pm_d     = pwdata[12:0];
      nbytes_d = nb_new;
      used_d   = 13'd0;
      clr_d    = '0;
      state_d  = ST_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pm_q        <= 13'd4096;
      nbytes_q    <= BW'(ResetBytes);
      used_q      <= 13'd0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pm_q     <= pm_d;
      nbytes_q <= nbytes_d;
      used_q   <= used_d;
      clr_q    <= clr_d;
      pend_q   <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    cnt_q     <= cnt_d;
    need_q    <= need_d;
    iss_q     <= iss_d;
    iss_end_q <= iss_end_d;
    first_q   <= first_d;
    last_q    <= last_d;
    ev_q      <= ev_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    run_q     <= run_d;
    runst_q   <= runst_d;
    fill_q    <= fill_d;
    fillcnt_q <= fillcnt_d;
    rok_q     <= rok_d;
    rpage_q   <= rpage_d;
    if (out_load) begin
      out_ok_q   <= rok_q;
      out_page_q <= rpage_q;
      out_used_q <= used_q;
    end
  end

  // bitmap storage, one byte per entry
  bpa_ram #(
    .WIDTH (8),
    .DEPTH (MapBytes)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  // used count never exceeds the managed pages
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(used_q) <= PW'({nbytes_q, 3'b000}))
    else $error("used count beyond managed pages");

  // a failed request reports page zero
  a_fail_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> result_page_o == 12'd0)
    else $error("failed request with nonzero page");

  // scan writes only a byte that was just read
  a_scan_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && state_q == ST_SCAN |-> pend_q)
    else $error("scan write without read data");

  // a config write empties the map and starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> state_q == ST_CLEAR && used_q == 13'd0)
    else $error("config write did not restart clearing");
`endif

endmodule

`default_nettype wire

// ===== tb/bitmap_page_allocator_checker.sv =====
// bitmap_page_allocator_checker: watches the request, result and register ports,
// keeps its own copy of the page bitmap and compares every result word
// depends on bpa_pkg for the request codes; instantiated by bitmap_page_allocator_tb
`timescale 1ns / 1ps

module bitmap_page_allocator_checker #(
  parameter int unsigned MAX_PAGES  = 4096,
  parameter logic [2:0]  PAGES_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  req_type_i,
  input  logic [12:0] page_count_i,
  input  logic [11:0] start_page_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        ok_i,
  input  logic [11:0] result_page_i,
  input  logic [12:0] used_pages_i,
  output int          fail_count_o,
  output int          pending_o
);

  import bpa_pkg::*;

  localparam int MapBytes = MAX_PAGES / 8;

  // one expected result word
  typedef struct packed {
    logic        ok;
    logic [11:0] page;
    logic [12:0] used;
  } grant_t;

  logic [7:0] page_map [MapBytes];
  int         used_cnt;
  logic [12:0] pages_cfg;
  grant_t     grant_q [$];
  int         errs;

  // managed pages: register clipped to the bitmap, whole bytes only
  function automatic int managed_pages();
    int n;
    n = int'(pages_cfg);
    if (n > MAX_PAGES) n = MAX_PAGES;
    return n & ~7;
  endfunction

  function automatic void clear_map();
    foreach (page_map[b]) page_map[b] = 8'h00;
    used_cnt = 0;
  endfunction

  // set or clear one page, counting only real changes
  function automatic void mark_page(int p, bit used);
    int b;
    int k;
    b = p >> 3;
    k = p & 7;
    if (b >= MapBytes) return;
    if (used && !page_map[b][k]) begin
      page_map[b][k] = 1'b1;
      used_cnt++;
    end else if (!used && page_map[b][k]) begin
      page_map[b][k] = 1'b0;
      used_cnt--;
    end
  endfunction

  // first run of cnt free bits inside a single byte
  function automatic bit grab_in_byte(int cnt, output int first);
    int run;
    int from;
    first = 0;
    for (int i = 0; i < managed_pages() / 8; i++) begin
      run  = 0;
      from = 0;
      for (int j = 0; j < 8; j++) begin
        if (page_map[i][j]) begin
          run = 0;
        end else begin
          if (run == 0) from = j;
          run++;
          if (run == cnt) begin
            for (int k = from; k < from + cnt; k++) mark_page(i * 8 + k, 1'b1);
            first = i * 8 + from;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // first run of whole free bytes, marked full
  function automatic bit grab_bytes(int cnt, output int first);
    int need;
    int run;
    int from;
    need  = (cnt + 7) >> 3;
    run   = 0;
    from  = 0;
    first = 0;
    for (int i = 0; i < managed_pages() / 8; i++) begin
      if (page_map[i] != 8'h00) begin
        run = 0;
      end else begin
        if (run == 0) from = i;
        run++;
        if (run == need) begin
          for (int k = from; k < from + need; k++) begin
            page_map[k] = 8'hFF;
            used_cnt += 8;
          end
          first = from * 8;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // apply one request to the bitmap copy and form its result word
  function automatic grant_t serve_request(logic [1:0] kind, int cnt, int st);
    grant_t g;
    int     first;
    int     lim;
    bit     ok;
    lim   = managed_pages();
    first = 0;
    ok    = 1'b0;
    case (kind)
      REQ_ALLOC: begin
        if (cnt >= 8) ok = grab_bytes(cnt, first);
        else if (cnt > 0) ok = grab_in_byte(cnt, first);
        if (!ok) first = 0;
      end
      REQ_RELEASE: begin
        for (int p = st; p < st + cnt && p < lim; p++) mark_page(p, 1'b0);
        first = st;
        ok    = 1'b1;
      end
      REQ_RESERVE: begin
        for (int p = 0; p < cnt && p < lim; p++) mark_page(p, 1'b1);
        ok = 1'b1;
      end
      default: ;
    endcase
    g.ok   = ok;
    g.page = 12'(first);
    g.used = 13'(used_cnt);
    return g;
  endfunction

  function automatic void flag_field(string what, int want, int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    errs++;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      pages_cfg = 13'd4096;
      clear_map();
      grant_q.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t ns: result word with none expected, got ok %0d page %0d used %0d",
                   $time, ok_i, result_page_i, used_pages_i);
          errs++;
        end else begin
          want = grant_q.pop_front();
          if (want.ok !== ok_i) flag_field("ok", want.ok, ok_i);
          if (want.page !== result_page_i) flag_field("result_page", want.page, result_page_i);
          if (want.used !== used_pages_i) flag_field("used_pages", want.used, used_pages_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        grant_q.push_back(serve_request(req_type_i, int'(page_count_i), int'(start_page_i)));
      end
      // register write resizes and clears the map
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == PAGES_ADDR) begin
        pages_cfg = pwdata_i[12:0];
        clear_map();
      end
      fail_count_o <= errs;
      pending_o    <= grant_q.size();
    end
  end

endmodule

// ===== tb/bitmap_page_allocator_tb.sv =====
// bitmap_page_allocator_tb: drives requests and register writes into the allocator
// with random gaps and result stalls; checking lives in bitmap_page_allocator_checker
// depends on bpa_pkg, bitmap_page_allocator and bitmap_page_allocator_checker
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [2:0] PAGES_ADDR  = 3'd0;
  localparam int         STALL_LIMIT = 8000;
  localparam int         DRAIN       = 1100;
  localparam int         PHASE_WORDS = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = PAGES_ADDR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_ALLOC;
  logic [12:0] page_count = '0;
  logic [11:0] start_page = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [11:0] result_page;
  logic [12:0] used_pages;
  int          fails;
  int          pending;
  bit          no_gaps = 1'b0;
  int          managed = 4096;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_page_allocator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .page_count_i  (page_count),
    .start_page_i  (start_page),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .ok_o          (ok),
    .result_page_o (result_page),
    .used_pages_o  (used_pages)
  );

  bitmap_page_allocator_checker #(
    .PAGES_ADDR (PAGES_ADDR)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .req_type_i    (req_type),
    .page_count_i  (page_count),
    .start_page_i  (start_page),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .ok_i          (ok),
    .result_page_i (result_page),
    .used_pages_i  (used_pages),
    .fail_count_o  (fails),
    .pending_o     (pending)
  );

  // one request word, after a random gap
  task automatic send(logic [1:0] kind, int cnt, int st);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    page_count <= 13'(cnt);
    start_page <= 12'(st);
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_pages(int value);
    int n;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAGES_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n = (value > 4096) ? 4096 : value;
    managed = n & ~7;
  endtask

  // mostly small allocations and releases near the used region
  task automatic random_word();
    logic [1:0] kind;
    int cnt;
    int st;
    int r;
    int span;
    span = (managed == 0) ? 4096 : ((managed < 512) ? managed : 512);
    st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, span - 1);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      kind = REQ_ALLOC;
      r = $urandom_range(0, 19);
      if (r < 14) cnt = $urandom_range(1, 7);
      else if (r < 19) cnt = $urandom_range(8, 64);
      else cnt = $urandom_range(0, 8191);
    end else if (r < 88) begin
      kind = REQ_RELEASE;
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 16);
    end else if (r < 95) begin
      kind = REQ_RESERVE;
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 32);
    end else begin
      kind = REQ_UNKNOWN;
      cnt = $urandom_range(0, 8191);
    end
    send(kind, cnt, st);
  endtask

  // result side: random stall before each word
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("bitmap_page_allocator_tb NOT OK");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int settings [9] = '{64, 4096, 8, 136, 8191, 1000, 13, 4096, 520};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // full map after reset: small and large fits, zero count, release, reserve
    send(REQ_ALLOC, 1, 0);
    send(REQ_ALLOC, 7, 4095);
    send(REQ_ALLOC, 8, 0);
    send(REQ_ALLOC, 9, 0);
    send(REQ_ALLOC, 0, 0);
    send(REQ_RELEASE, 3, 0);
    send(REQ_ALLOC, 3, 0);
    send(REQ_RESERVE, 20, 0);
    send(REQ_RELEASE, 4096, 4095);
    send(REQ_RELEASE, 4096, 0);
    send(REQ_ALLOC, 4096, 0);
    send(REQ_ALLOC, 1, 0);
    send(REQ_RELEASE, 0, 2048);
    send(REQ_RESERVE, 0, 0);
    send(REQ_UNKNOWN, 8191, 4095);
    send(REQ_RESERVE, 8191, 0);
    send(REQ_RELEASE, 8191, 4095);
    send(REQ_RELEASE, 8191, 0);
    send(REQ_ALLOC, 4095, 0);
    send(REQ_ALLOC, 8191, 0);

    // single byte map: pages past the end are ignored
    settle();
    write_pages(8);
    send(REQ_ALLOC, 8, 0);
    send(REQ_ALLOC, 1, 0);
    send(REQ_RELEASE, 1, 4095);

    // map of zero pages: every allocate fails
    settle();
    write_pages(3);
    send(REQ_ALLOC, 1, 0);
    send(REQ_RESERVE, 8, 0);

    // random phases over several map sizes
    foreach (settings[s]) begin
      settle();
      write_pages(settings[s]);
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        random_word();
      end
    end

    settle();
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("bitmap_page_allocator_tb OK");
    end else begin
      $display("bitmap_page_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
